/* rtl/core/limited_n_residual_distributor_unit_defines.svh */
// assertion macros for the limited n residual distributor
`ifndef LIMITED_N_RESIDUAL_DISTRIBUTOR_UNIT_DEFINES_SVH
`define LIMITED_N_RESIDUAL_DISTRIBUTOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define LNRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define LNRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lnrd_pkg.sv */
// shared types, constants and arithmetic helpers of the residual distributor
package lnrd_pkg;

    localparam int LNRD_MAX_NODES = 4;

    localparam int DATA_W  = 32;
    localparam int H2_W    = 48;
    localparam int INVH_W  = 32;
    localparam int EPS_W   = 16;
    localparam int SUM_W   = 40;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NUM_W   = 80;
    localparam int DEN_W   = 48;
    localparam int Q_W     = 48;
    localparam int DSH_W   = DEN_W + Q_W;
    localparam int STEP_W  = 6;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [H2_W-1:0]   H2_RST   = 48'd45035996;
    localparam logic [INVH_W-1:0] INVH_RST = 32'd163840000;
    localparam logic [EPS_W-1:0]  EPS_RST  = 16'd1;

    localparam logic [STEP_W-1:0] STEPS_Q   = 6'd33;
    localparam logic [STEP_W-1:0] STEPS_R1  = 6'd48;
    localparam logic [STEP_W-1:0] STEPS_R2  = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H2   = 2'd0,
        CFG_INVH = 2'd1,
        CFG_EPS  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic           ovf;
        logic [Q_W-1:0] q;
    } t_div_rsp;

    function automatic logic [63:0] f_abs64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic signed [63:0] f_sadd64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [PROD_W-1:0] v);
        if ((v[PROD_W-1:31] == '0) || (v[PROD_W-1:31] == '1)) begin
            return v[31:0];
        end
        return v[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // truncating quotient with saturation to the signed 32 bit range
    function automatic logic signed [31:0] f_div_fin(input logic neg, input logic nz,
                                                     input logic ovf,
                                                     input logic [Q_W-1:0] q);
        logic big_n;
        logic big_p;
        big_n = ovf || (q[Q_W-1:31] != '0);
        big_p = big_n || (q[30:0] == '1);
        if (nz) begin
            return '0;
        end
        if (neg) begin
            return big_n ? 32'sh8000_0000 : (32'd0 - q[31:0]);
        end
        return big_p ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

endpackage

/* rtl/core/limited_n_residual_distributor_unit.sv */
// Limited N-scheme residual distributor, one scalar equation, one cell at a time.
// Input channel: one node per transaction (value, k-plus, k, cell phi, last flag).
// A node is taken when i_in_valid is high and o_in_stall is low; a cell closes on
// i_last_node or on its MAX_NODES-th node.
// Output channel: one residual per node, in load order, with its index and a flag
// on the final residual; a transaction completes when o_out_valid is high and
// i_out_stall is low.
// Each node is taken in S_IDLE and its product accumulated in S_LACC. Closing a
// cell runs all divisions on one shared bit-serial divider (32, 33 or 48 steps
// each) and all products on one shared multiplier.
// The input stalls in S_LACC after each node and from the cell's last node
// until the last residual of the cell is taken; a stalled output holds its
// residual and the sequencer waits.
// Reset (synchronous, active low) empties the cell and loads the register
// defaults; configuration writes take effect at once. The user must see that they are
// made while idle; the block does not enforce it.
`include "limited_n_residual_distributor_unit_defines.svh"
module limited_n_residual_distributor_unit #(
    parameter int MAX_NODES = lnrd_pkg::LNRD_MAX_NODES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lnrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lnrd_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lnrd_pkg::DATA_W-1:0]  i_node_value,
    input  logic signed [lnrd_pkg::DATA_W-1:0]  i_upwind_coeff,
    input  logic signed [lnrd_pkg::DATA_W-1:0]  i_inflow_coeff,
    input  logic signed [lnrd_pkg::DATA_W-1:0]  i_cell_fluctuation,
    input  logic                                i_last_node,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lnrd_pkg::DATA_W-1:0]  o_node_residual,
    output logic [1:0]                          o_node_index,
    output logic                                o_last_result
);
    import lnrd_pkg::*;

    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int IW   = $clog2(MAX_NODES);
    localparam int NE_W = EPS_W + CW;
    localparam int SB_W = DATA_W + CW + 1;

    typedef enum logic [27:0] {
        S_IDLE   = 28'h0000001,
        S_LACC   = 28'h0000002,
        S_UT_SUM = 28'h0000004,
        S_UT_GO  = 28'h0000008,
        S_DWAIT  = 28'h0000010,
        S_UT_END = 28'h0000020,
        S_UB_GO  = 28'h0000040,
        S_UB_END = 28'h0000080,
        S_B_SUB  = 28'h0000100,
        S_B_MUL  = 28'h0000200,
        S_B_PN   = 28'h0000400,
        S_B_GO   = 28'h0000800,
        S_B_END  = 28'h0001000,
        S_TH_A   = 28'h0002000,
        S_TH_B   = 28'h0004000,
        S_TH_C   = 28'h0008000,
        S_TH_D   = 28'h0010000,
        S_TH_E   = 28'h0020000,
        S_R_GO   = 28'h0040000,
        S_R_BETA = 28'h0080000,
        S_R_M1   = 28'h0100000,
        S_R_M2   = 28'h0200000,
        S_R_M3   = 28'h0400000,
        S_R_M4   = 28'h0800000,
        S_R_M5   = 28'h1000000,
        S_R_M6   = 28'h2000000,
        S_R_M7   = 28'h4000000,
        S_R_OUT  = 28'h8000000
    } t_state;

    t_state r_state, n_state, r_ret;

    logic [H2_W-1:0]   r_h2;
    logic [INVH_W-1:0] r_inv_h;
    logic [EPS_W-1:0]  r_eps;

    logic signed [DATA_W-1:0] r_val   [MAX_NODES];
    logic signed [DATA_W-1:0] r_up    [MAX_NODES];
    logic signed [DATA_W-1:0] r_inf   [MAX_NODES];
    logic [DATA_W-1:0]        r_bplus [MAX_NODES];

    logic [CW-1:0]            r_count;
    logic [IW-1:0]            r_i;
    logic                     r_end;
    logic signed [63:0]       r_suv;
    logic signed [SUM_W-1:0]  r_sup;
    logic signed [SUM_W-1:0]  r_sval;
    logic [NE_W-1:0]          r_neps;
    logic signed [DATA_W-1:0] r_phi;

    logic signed [63:0]       r_tmp;
    logic                     r_dneg;
    logic                     r_dnz;
    logic signed [DATA_W-1:0] r_ut;
    logic signed [DATA_W-1:0] r_ubar;
    logic signed [DATA_W-1:0] r_um;
    logic [SB_W-1:0]          r_sumb;
    logic [31:0]              r_r;
    logic signed [DATA_W-1:0] r_theta;
    logic signed [DATA_W-1:0] r_beta;
    logic signed [49:0]       r_res;
    logic signed [DATA_W-1:0] r_kphi;
    logic signed [DATA_W-1:0] r_kh;
    logic signed [DATA_W-1:0] r_out;

    t_div_req                 w_req;
    t_div_rsp                 w_rsp;
    logic signed [MUL_W-1:0]  w_ma;
    logic signed [MUL_W-1:0]  w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_psh;
    logic signed [DATA_W-1:0] w_fin;
    logic signed [33:0]       w_den_b;
    logic signed [33:0]       w_thd;
    logic signed [33:0]       w_rs;
    logic [DATA_W-1:0]        w_ap;
    logic [DATA_W-1:0]        w_au;
    logic                     w_accept;
    logic                     w_last;
    logic                     w_r1_big;
    logic signed [DATA_W-1:0] w_pn;
    logic signed [32:0]       w_pe;
    logic signed [DATA_W-1:0] w_bp;
    logic [CW-1:0]            w_idx;

    lnrd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    lnrd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_idx      = r_count;
    assign w_last     = (CW'(r_i) == (r_count - CW'(1)));
    assign w_psh      = w_prod >>> 16;
    assign w_fin      = f_div_fin(r_dneg, r_dnz, w_rsp.ovf, w_rsp.q);
    assign w_den_b    = 34'(r_phi) + $signed(34'(r_neps));
    assign w_ap       = r_phi[31] ? (32'd0 - r_phi) : r_phi;
    assign w_au       = r_ubar[31] ? (32'd0 - r_ubar) : r_ubar;
    assign w_rs       = r_ubar[31] ? -$signed({2'b00, r_r}) : $signed({2'b00, r_r});
    assign w_thd      = w_rs + $signed(34'(r_eps));
    assign w_r1_big   = w_rsp.ovf || (w_rsp.q >= r_h2);
    assign w_pn       = f_sat32(w_psh);
    assign w_pe       = 33'(w_pn) + $signed(33'(r_eps));
    assign w_bp       = (w_fin > $signed(32'(r_eps))) ? w_fin : $signed(32'(r_eps));

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_IDLE: begin
                w_ma = 33'(i_upwind_coeff);
                w_mb = 33'(i_node_value);
            end
            S_B_MUL: begin
                w_ma = 33'(r_up[r_i]);
                w_mb = 33'(r_um);
            end
            S_R_M1: begin
                w_ma = 33'(r_beta);
                w_mb = 33'(r_phi);
            end
            S_R_M2: begin
                w_ma = 33'(r_inf[r_i]);
                w_mb = 33'(r_phi);
            end
            S_R_M4: begin
                w_ma = 33'(r_kphi);
                w_mb = $signed({1'b0, r_inv_h});
            end
            S_R_M6: begin
                w_ma = 33'(r_kh);
                w_mb = 33'(r_theta);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // divider request
    always_comb begin
        w_req = '0;
        case (r_state)
            S_UT_GO: begin
                w_req.start = 1'b1;
                w_req.num   = NUM_W'(f_abs64(r_tmp));
                w_req.den   = DEN_W'(f_abs64(64'(r_sup)));
                w_req.steps = STEPS_Q;
            end
            S_UB_GO: begin
                w_req.start = 1'b1;
                w_req.num   = NUM_W'(f_abs64(64'(r_sval)));
                w_req.den   = DEN_W'(r_count);
                w_req.steps = STEPS_Q;
            end
            S_B_GO: begin
                w_req.start = 1'b1;
                w_req.num   = NUM_W'(f_abs64(r_tmp));
                w_req.den   = DEN_W'(f_abs64(64'(w_den_b)));
                w_req.steps = STEPS_Q;
            end
            S_TH_A: begin
                w_req.start = (r_phi != '0) && (w_au != '0) && (r_h2 != '0);
                w_req.num   = NUM_W'({w_ap, 32'd0});
                w_req.den   = DEN_W'(w_au);
                w_req.steps = STEPS_R1;
            end
            S_TH_B: begin
                w_req.start = !w_r1_big;
                w_req.num   = {w_rsp.q, 32'd0};
                w_req.den   = r_h2;
                w_req.steps = STEPS_R2;
            end
            S_TH_D: begin
                w_req.start = (w_thd != '0);
                w_req.num   = NUM_W'(1) << 32;
                w_req.den   = DEN_W'(f_abs64(64'(w_thd)));
                w_req.steps = STEPS_Q;
            end
            S_R_GO: begin
                w_req.start = 1'b1;
                w_req.num   = NUM_W'({r_bplus[r_i], 16'd0});
                w_req.den   = DEN_W'(r_sumb);
                w_req.steps = STEPS_Q;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   n_state = w_accept ? S_LACC : S_IDLE;
            S_LACC:   n_state = r_end ? S_UT_SUM : S_IDLE;
            S_UT_SUM: n_state = S_UT_GO;
            S_UT_GO:  n_state = S_DWAIT;
            S_DWAIT:  n_state = w_rsp.done ? r_ret : S_DWAIT;
            S_UT_END: n_state = S_UB_GO;
            S_UB_GO:  n_state = S_DWAIT;
            S_UB_END: n_state = S_B_SUB;
            S_B_SUB:  n_state = S_B_MUL;
            S_B_MUL:  n_state = S_B_PN;
            S_B_PN:   n_state = S_B_GO;
            S_B_GO:   n_state = S_DWAIT;
            S_B_END:  n_state = w_last ? S_TH_A : S_B_SUB;
            S_TH_A: begin
                if (r_phi == '0) begin
                    n_state = S_R_GO;
                end else if (w_req.start) begin
                    n_state = S_DWAIT;
                end else begin
                    n_state = S_TH_D;
                end
            end
            S_TH_B:   n_state = w_r1_big ? S_TH_D : S_DWAIT;
            S_TH_C:   n_state = S_TH_D;
            S_TH_D:   n_state = (w_thd == '0) ? S_R_GO : S_DWAIT;
            S_TH_E:   n_state = S_R_GO;
            S_R_GO:   n_state = S_DWAIT;
            S_R_BETA: n_state = S_R_M1;
            S_R_M1:   n_state = S_R_M2;
            S_R_M2:   n_state = S_R_M3;
            S_R_M3:   n_state = S_R_M4;
            S_R_M4:   n_state = S_R_M5;
            S_R_M5:   n_state = S_R_M6;
            S_R_M6:   n_state = S_R_M7;
            S_R_M7:   n_state = S_R_OUT;
            S_R_OUT: begin
                if (!i_out_stall) begin
                    n_state = w_last ? S_IDLE : S_R_GO;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_h2    <= H2_RST;
            r_inv_h <= INVH_RST;
            r_eps   <= EPS_RST;
            r_count <= '0;
            r_i     <= '0;
            r_end   <= 1'b0;
            r_suv   <= '0;
            r_sup   <= '0;
            r_sval  <= '0;
            r_neps  <= '0;
            r_phi   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_H2:   r_h2    <= i_cfg_wr_data[H2_W-1:0];
                    CFG_INVH: r_inv_h <= i_cfg_wr_data[INVH_W-1:0];
                    CFG_EPS:  r_eps   <= i_cfg_wr_data[EPS_W-1:0];
                    default:  ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sup   <= r_sup + SUM_W'(i_upwind_coeff);
                        r_sval  <= r_sval + SUM_W'(i_node_value);
                        r_neps  <= r_neps + NE_W'(r_eps);
                        r_phi   <= i_cell_fluctuation;
                        r_count <= r_count + CW'(1);
                        r_end   <= i_last_node || (r_count == CW'(MAX_NODES - 1));
                    end
                end
                S_LACC:   r_suv <= f_sadd64(r_suv, w_prod[63:0]);
                S_UT_GO:  r_ret <= S_UT_END;
                S_UB_GO:  r_ret <= S_UB_END;
                S_B_GO:   r_ret <= S_B_END;
                S_TH_A:   r_ret <= S_TH_B;
                S_TH_B:   r_ret <= S_TH_C;
                S_TH_D:   r_ret <= S_TH_E;
                S_R_GO:   r_ret <= S_R_BETA;
                S_UB_END: r_i <= '0;
                S_B_END:  r_i <= w_last ? '0 : r_i + IW'(1);
                S_R_OUT: begin
                    if (!i_out_stall) begin
                        if (w_last) begin
                            r_i     <= '0;
                            r_count <= '0;
                            r_suv   <= '0;
                            r_sup   <= '0;
                            r_sval  <= '0;
                            r_neps  <= '0;
                        end else begin
                            r_i <= r_i + IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_val[w_idx[IW-1:0]] <= i_node_value;
                    r_up[w_idx[IW-1:0]]  <= i_upwind_coeff;
                    r_inf[w_idx[IW-1:0]] <= i_inflow_coeff;
                end
            end
            S_UT_SUM: begin
                r_tmp <= f_sadd64(r_suv, -$signed({{16{r_phi[31]}}, r_phi, 16'd0}));
            end
            S_UT_GO: begin
                r_dneg <= r_tmp[63] ^ r_sup[SUM_W-1];
                r_dnz  <= (r_tmp == '0);
            end
            S_UT_END: r_ut <= w_fin;
            S_UB_GO: begin
                r_dneg <= r_sval[SUM_W-1];
                r_dnz  <= (r_sval == '0);
            end
            S_UB_END: begin
                r_ubar <= w_fin;
                r_sumb <= '0;
            end
            S_B_SUB: begin
                r_um <= f_sat32(PROD_W'(r_val[r_i]) - PROD_W'(r_ut));
            end
            S_B_PN: r_tmp <= {{15{w_pe[32]}}, w_pe, 16'd0};
            S_B_GO: begin
                r_dneg <= r_tmp[63] ^ w_den_b[33];
                r_dnz  <= (r_tmp == '0);
            end
            S_B_END: begin
                r_bplus[r_i] <= w_bp;
                r_sumb       <= r_sumb + SB_W'(unsigned'(w_bp));
            end
            S_TH_A: begin
                r_theta <= 32'sh0001_0000;
                r_r     <= 32'hFFFF_FFFF;
                r_dnz   <= 1'b0;
            end
            S_TH_B: begin
                r_r <= 32'hFFFF_FFFF;
            end
            S_TH_C: r_r <= w_rsp.q[31:0];
            S_TH_D: begin
                r_theta <= 32'sh0001_0000;
                r_dneg  <= w_thd[33];
            end
            S_TH_E: begin
                if (r_dneg) begin
                    r_theta <= (w_rsp.q[32:0] > 33'h0_8000_0000) ?
                               32'sh8000_0000 : (32'd0 - w_rsp.q[31:0]);
                end else begin
                    r_theta <= (w_rsp.q[32:0] > 33'h0_0001_0000) ?
                               32'sh0001_0000 : w_rsp.q[31:0];
                end
            end
            S_R_GO: begin
                r_dneg <= 1'b0;
                r_dnz  <= (r_bplus[r_i] == '0);
            end
            S_R_BETA: r_beta <= w_fin;
            S_R_M2:   r_res  <= w_psh[49:0];
            S_R_M3:   r_kphi <= f_sat32(w_psh);
            S_R_M5:   r_kh   <= f_sat32(w_psh);
            S_R_M7:   r_out  <= f_sat32(PROD_W'(r_res) + w_psh);
            default: ;
        endcase
    end

    assign o_out_valid     = (r_state == S_R_OUT);
    assign o_node_residual = r_out;
    assign o_node_index    = r_i[1:0];
    assign o_last_result   = w_last;

    `LNRD_ASSERT_NOW(a_out_blocks_in, o_out_valid, o_in_stall, "input open while a residual waits")
    `LNRD_ASSERT_NOW(a_count_room, !o_in_stall, r_count <= CW'(MAX_NODES - 1), "cell overfull while idle")
    `LNRD_ASSERT_NEXT(a_cell_clear, o_out_valid && !i_out_stall && o_last_result, (r_count == '0) && (r_sup == '0), "cell state not cleared")
    `LNRD_ASSERT_NOW(a_div_wait, w_rsp.done, r_state == S_DWAIT, "divider finished outside wait")

endmodule

/* rtl/core/lnrd_div.sv */
// shared restoring divider, one quotient bit per cycle with overflow check
module lnrd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lnrd_pkg::t_div_req i_req,
    output lnrd_pkg::t_div_rsp o_rsp
);
    import lnrd_pkg::*;

    logic              r_busy;
    logic              r_first;
    logic              r_done;
    logic              r_ovf;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [Q_W-1:0]    r_q;
    logic              w_ge;
    logic              w_load;

    assign w_ge   = DSH_W'(r_rem) >= r_dsh;
    assign w_load = i_req.start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (w_load) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= i_req.steps;
            end else if (r_busy) begin
                r_first <= 1'b0;
                if (!r_first) begin
                    r_cnt <= r_cnt - STEP_W'(1);
                    if (r_cnt == STEP_W'(1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem <= i_req.num;
            r_dsh <= DSH_W'(i_req.den) << i_req.steps;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            if (r_first) begin
                r_ovf <= w_ge;
            end else begin
                r_q <= {r_q[Q_W-2:0], w_ge};
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[NUM_W-1:0];
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.q    = r_q;

endmodule

/* rtl/core/lnrd_mul.sv */
// shared signed multiplier with registered product
module lnrd_mul (
    input  logic                                 i_clk,
    input  logic signed [lnrd_pkg::MUL_W-1:0]    i_a,
    input  logic signed [lnrd_pkg::MUL_W-1:0]    i_b,
    output logic signed [lnrd_pkg::PROD_W-1:0]   o_p
);
    import lnrd_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* test/tb_top.sv */
// self-checking testbench for the limited n-scheme residual distributor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lnrd_pkg::*;

    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
    localparam int     WD_LIMIT = 6000;

    typedef struct {
        int signed value;
        int signed upwind;
        int signed inflow;
        int signed fluct;
        bit        last;
    } t_node;

    typedef struct {
        int signed residual;
        bit [1:0]  index;
        bit        last;
    } t_residual;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [31:0]   i_node_value;
    logic signed [31:0]   i_upwind_coeff;
    logic signed [31:0]   i_inflow_coeff;
    logic signed [31:0]   i_cell_fluctuation;
    logic                 i_last_node;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [31:0]   o_node_residual;
    logic [1:0]           o_node_index;
    logic                 o_last_result;

    limited_n_residual_distributor_unit dut (.*);

    // predictor state
    bit [47:0]   h2_reg;
    bit [31:0]   invh_reg;
    bit [15:0]   eps_reg;
    int signed   cell_values [LNRD_MAX_NODES];
    int signed   cell_upwind [LNRD_MAX_NODES];
    int signed   cell_inflow [LNRD_MAX_NODES];
    int          cell_count;
    longint      acc_kp_u;
    longint      acc_kp;
    longint      acc_u;
    int signed   cell_phi;

    t_residual   pending_residuals[$];
    int          fail_count;
    int          nodes_sent;
    int          residuals_seen;
    int          cells_closed;
    int          idle_cycles;
    bit          tx_no_gaps;
    bit          rx_no_gaps;
    int          rx_wait;
    int          rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int signed sat32(longint v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic longint sadd64(longint a, longint b);
        if (b > 0 && a > S64_MAX - b) return S64_MAX;
        if (b < 0 && a < S64_MIN - b) return S64_MIN;
        return a + b;
    endfunction

    function automatic bit [63:0] mag64(longint v);
        return (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic int signed quotient32(longint num, longint den);
        bit [63:0] un, ud, q;
        bit        neg;
        un = mag64(num);
        ud = mag64(den);
        neg = (num < 0) != (den < 0);
        if (num == 0) return 0;
        if (ud == 0) return (num > 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        q = un / ud;
        if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -int'(q);
        return (q >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(q);
    endfunction

    function automatic longint theta_q16(int signed phi, int signed ubar);
        bit [63:0] ap, au, q1, rem, r, t;
        longint    rs, d;
        ap = mag64(longint'(phi));
        au = mag64(longint'(ubar));
        if (phi == 0) return 65536;
        r = 64'hFFFF_FFFF;
        if (au != 0 && h2_reg != 0) begin
            q1 = (ap << 32) / au;
            if (q1 < {16'd0, h2_reg}) begin
                rem = q1;
                r = 0;
                for (int i = 0; i < 32; i++) begin
                    rem = rem << 1;
                    r = r << 1;
                    if (rem >= {16'd0, h2_reg}) begin
                        rem = rem - {16'd0, h2_reg};
                        r[0] = 1'b1;
                    end
                end
            end
        end
        rs = (ubar < 0) ? -longint'(r) : longint'(r);
        d = rs + longint'(eps_reg);
        if (d == 0) return 65536;
        if (d > 0) begin
            t = 64'h1_0000_0000 / 64'(d);
            return (t > 65536) ? 65536 : longint'(t);
        end
        t = 64'h1_0000_0000 / mag64(d);
        return (t > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(t);
    endfunction

    // accumulates one node and, when the cell closes, queues its residuals
    task automatic distribute_node(t_node nd);
        int          idx, n, ut, ubar, um, pn, bn, beta, kphi, kh;
        int          bplus [LNRD_MAX_NODES];
        longint      eps, temp, sumb, theta, res, dif;
        t_residual   exp_r;
        idx = (cell_count >= LNRD_MAX_NODES) ? LNRD_MAX_NODES - 1 : cell_count;
        eps = longint'(eps_reg);
        sumb = 0;
        cell_values[idx] = nd.value;
        cell_upwind[idx] = nd.upwind;
        cell_inflow[idx] = nd.inflow;
        acc_kp_u = sadd64(acc_kp_u, longint'(nd.upwind) * longint'(nd.value));
        acc_kp += nd.upwind;
        acc_u += nd.value;
        cell_phi = nd.fluct;
        cell_count = idx + 1;
        if (!nd.last && cell_count < LNRD_MAX_NODES) return;
        n = cell_count;
        temp = sadd64(acc_kp_u, -longint'(cell_phi) * 65536);
        ut = quotient32(temp, acc_kp);
        ubar = sat32(acc_u / longint'(n));
        for (int i = 0; i < n; i++) begin
            um = sat32(longint'(cell_values[i]) - longint'(ut));
            pn = sat32((longint'(cell_upwind[i]) * longint'(um)) >>> 16);
            bn = quotient32((longint'(pn) + eps) * 65536,
                            longint'(cell_phi) + longint'(n) * eps);
            bplus[i] = (longint'(bn) > eps) ? bn : int'(eps);
            sumb += bplus[i];
        end
        theta = theta_q16(cell_phi, ubar);
        for (int i = 0; i < n; i++) begin
            beta = quotient32(longint'(bplus[i]) * 65536, sumb);
            res = (longint'(beta) * longint'(cell_phi)) >>> 16;
            kphi = sat32((longint'(cell_inflow[i]) * longint'(cell_phi)) >>> 16);
            kh = sat32((longint'(kphi) * longint'(invh_reg)) >>> 16);
            dif = (longint'(kh) * theta) >>> 16;
            exp_r.residual = sat32(res + dif);
            exp_r.index = 2'(i);
            exp_r.last = (i + 1 == n);
            pending_residuals.push_back(exp_r);
        end
        cells_closed++;
        cell_count = 0;
        acc_kp_u = 0;
        acc_kp = 0;
        acc_u = 0;
    endtask

    task automatic send_node(t_node nd);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_node_value = nd.value;
        i_upwind_coeff = nd.upwind;
        i_inflow_coeff = nd.inflow;
        i_cell_fluctuation = nd.fluct;
        i_last_node = nd.last;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        distribute_node(nd);
        nodes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_residuals.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, bit [47:0] data);
        wait_drained();
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wr_data = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_H2:   h2_reg = data;
            CFG_INVH: invh_reg = data[31:0];
            CFG_EPS:  eps_reg = data[15:0];
            default: ;
        endcase
    endtask

    function automatic int signed pick_q16();
        case ($urandom_range(0, 5))
            0:       return int'($urandom());
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh8000_0000;
            3:       return 0;
            default: return $urandom_range(0, 20 * 65536) - 10 * 65536;
        endcase
    endfunction

    // n nodes with random content; forced leaves last_node low on every node
    task automatic send_cell(int n, bit forced);
        t_node nd;
        int signed phi;
        phi = pick_q16();
        for (int i = 0; i < n; i++) begin
            nd.value = pick_q16();
            nd.upwind = ($urandom_range(0, 3) == 0) ? pick_q16()
                                                     : $urandom_range(0, 4 * 65536);
            nd.inflow = pick_q16();
            nd.fluct = ($urandom_range(0, 4) == 0) ? pick_q16() : phi;
            nd.last = !forced && (i == n - 1);
            send_node(nd);
        end
    endtask

    task automatic send_fixed(int signed v, int signed kp, int signed k,
                              int signed phi, bit last);
        t_node nd;
        nd.value = v;
        nd.upwind = kp;
        nd.inflow = k;
        nd.fluct = phi;
        nd.last = last;
        send_node(nd);
    endtask

    task automatic test_directed();
        send_fixed(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_fixed(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        send_fixed(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_fixed(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        // zero fluctuation
        send_fixed(32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000, 0, 1'b0);
        send_fixed(32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 1'b1);
        // zero k-plus sum
        send_fixed(32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0000_4000, 1'b0);
        send_fixed(32'sh0002_0000, 0, 32'sh0001_0000, 32'sh0000_4000, 1'b1);
        // negative mean value
        send_fixed(-32'sh0005_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b0);
        send_fixed(-32'sh0003_0000, 32'sh0002_0000, -32'sh0001_0000, 32'sh0002_0000, 1'b1);
        // single node cell
        send_fixed(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 1'b1);
        // overlong cell, closed by node count, then a fresh cell
        for (int i = 0; i < 4; i++)
            send_fixed(32'sh0001_0000 * (i + 1), 32'sh0000_8000, 32'sh0000_1000,
                       32'sh0000_3000 + i, 1'b0);
        send_fixed(0, 0, 0, 0, 1'b1);
        // zero mean value
        send_fixed(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_fixed(-32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_H2, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_INVH, 48'h0000_FFFF_FFFF);
        write_reg(CFG_EPS, 48'd65535);
        repeat (3) send_cell($urandom_range(1, 4), 1'b0);
        write_reg(CFG_H2, 48'd0);
        write_reg(CFG_INVH, 48'd0);
        write_reg(CFG_EPS, 48'd0);
        repeat (3) send_cell($urandom_range(1, 4), 1'b0);
        write_reg(CFG_H2, 48'd1);
        write_reg(CFG_INVH, 48'h0001_0000);
        write_reg(CFG_EPS, 48'd1);
        repeat (3) send_cell($urandom_range(1, 4), 1'b0);
        write_reg(CFG_H2, 48'({$urandom(), $urandom()}));
        write_reg(CFG_INVH, 48'($urandom()));
        write_reg(CFG_EPS, 48'($urandom_range(1, 65535)));
        repeat (2) send_cell($urandom_range(1, 4), 1'b0);
        write_reg(CFG_H2, 48'd45035996);
        write_reg(CFG_INVH, 48'd163840000);
        write_reg(CFG_EPS, 48'd1);
    endtask

    task automatic test_random();
        int start;
        start = nodes_sent;
        while (nodes_sent - start < 50) begin
            tx_no_gaps = ($urandom_range(0, 5) == 0);
            rx_no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0) send_cell(4, 1'b1);
            else send_cell($urandom_range(1, 4), 1'b0);
        end
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        tx_no_gaps = 1'b1;
        rx_hold = 300;
        repeat (3) send_cell(4, 1'b0);
        tx_no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_cell(3, 1'b0);
        wait_drained();
        send_cell(2, 1'b0);
    endtask

    // result side stall generation
    initial begin
        i_out_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_stall = 1'b1;
                rx_hold--;
            end else if (rx_wait > 0) begin
                i_out_stall = 1'b1;
                rx_wait--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_residual exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            residuals_seen++;
            if (pending_residuals.size() == 0) begin
                $error("unexpected residual %0d", o_node_residual);
                fail_count++;
            end else begin
                exp_r = pending_residuals.pop_front();
                if (o_node_residual !== exp_r.residual) begin
                    $error("node_residual expected %0d actual %0d",
                           exp_r.residual, o_node_residual);
                    fail_count++;
                end
                if (o_node_index !== exp_r.index) begin
                    $error("node_index expected %0d actual %0d",
                           exp_r.index, o_node_index);
                    fail_count++;
                end
                if (o_last_result !== exp_r.last) begin
                    $error("last_result expected %0d actual %0d",
                           exp_r.last, o_last_result);
                    fail_count++;
                end
            end
            rx_wait = rx_no_gaps ? 0 : $urandom_range(0, 15);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_H2;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_node_value = '0;
        i_upwind_coeff = '0;
        i_inflow_coeff = '0;
        i_cell_fluctuation = '0;
        i_last_node = 1'b0;
        h2_reg = H2_RST;
        invh_reg = INVH_RST;
        eps_reg = EPS_RST;
        cell_count = 0;
        acc_kp_u = 0;
        acc_kp = 0;
        acc_u = 0;
        cell_phi = 0;
        fail_count = 0;
        nodes_sent = 0;
        residuals_seen = 0;
        cells_closed = 0;
        idle_cycles = 0;
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;
        rx_wait = 0;
        rx_hold = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_config_sweep();
        test_random();
        test_backpressure();
        test_drain_pause();

        wait_drained();
        $display("covered %0d nodes in %0d cells, %0d residuals checked,",
                 nodes_sent, cells_closed, residuals_seen);
        $display("register extremes, forced cell ends and long output back-pressure");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
